### rtl/voxel_face_vertex_emitter_macros.svh
// assertion macros shared by the voxel face vertex emitter modules
// expects signals named clock and reset in the using module
`ifndef VOXEL_FACE_VERTEX_EMITTER_MACROS_SVH
`define VOXEL_FACE_VERTEX_EMITTER_MACROS_SVH

// condition holds at every edge out of reset
`define VFVE_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VFVE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define VFVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vfve_pkg.sv
// types, constants and corner tables for the voxel face vertex emitter
// no dependencies
package vfve_pkg;

   localparam int CHUNK_EDGE          = 16;
   localparam int ATLAS_TILES_PER_ROW = 16;

   // power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int NUM_FACES     = 6;
   localparam int VERTS_PER_FACE = 6;

   localparam int REQ_BITS   = 74;
   localparam int REQ_TDATA_W = 80;
   localparam int VERT_BITS  = 91;
   localparam int RSP_TDATA_W = 96;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Z = 2'd2;

   localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_FACE - 1);

   // request fields, last field in the low bits
   typedef struct packed {
      logic [5:0][7:0] tiles;     // +y, -y, -x, +x, -z, +z from low byte
      logic [5:0]      face_mask;
      logic [7:0]      block_kind;
      logic [3:0]      block_z;
      logic [3:0]      block_y;
      logic [3:0]      block_x;
   } req_type;

   typedef struct packed {
      logic [5:0][7:0]    tiles;
      logic [5:0]         face_mask;
      logic signed [24:0] base_z;
      logic signed [24:0] base_y;
      logic signed [24:0] base_x;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // response vertex, last field in the low bits
   typedef struct packed {
      logic signed [1:0]  normal_z;
      logic signed [1:0]  normal_y;
      logic signed [1:0]  normal_x;
      logic [4:0]         tex_v;
      logic [4:0]         tex_u;
      logic signed [24:0] pos_z;
      logic signed [24:0] pos_y;
      logic signed [24:0] pos_x;
   } vert_type;

   // corner bits {x, y, z, u, v}
   localparam logic [4:0] CORNER_TAB [0:5][0:5] = '{
      '{5'b01001, 5'b01100, 5'b11110, 5'b01001, 5'b11110, 5'b11011},
      '{5'b00000, 5'b10111, 5'b00101, 5'b00000, 5'b10010, 5'b10111},
      '{5'b00011, 5'b00101, 5'b01100, 5'b00011, 5'b01100, 5'b01010},
      '{5'b10001, 5'b11110, 5'b10111, 5'b10001, 5'b11000, 5'b11110},
      '{5'b00001, 5'b01000, 5'b11010, 5'b00001, 5'b11010, 5'b10011},
      '{5'b00111, 5'b11100, 5'b01110, 5'b00111, 5'b10101, 5'b11100}
   };

   // normal codes {x, y, z}, two bits each
   localparam logic [5:0] NORMAL_TAB [0:5] = '{
      6'b00_01_00, 6'b00_11_00, 6'b11_00_00, 6'b01_00_00, 6'b00_00_11, 6'b00_00_01
   };

endpackage

### rtl/voxel_face_vertex_emitter.sv
// voxel face vertex emitter: one voxel in, up to 36 triangle vertices out
// depends on vfve_pkg, vfve_front, vfve_queue and vfve_back
//
// usage
//   req channel: one voxel per request; req_tdata holds block_x, block_y,
//   block_z, block_kind, face_mask and six atlas tile indices.
//   csr channel: writes origin_x (index 0), origin_y (1), origin_z (2);
//   always ready; write only while no voxel is in flight.
//   rsp channel: one vertex per transfer, rsp_tlast on the final vertex
//   of a voxel. Empty voxels, voxels with no visible face and voxels
//   outside the chunk produce no transfers.
// flow and throughput
//   a voxel passes the queue and the walker on its way to the vertex
//   register. the walker emits one vertex per cycle, six per visible
//   face, while rsp_tready allows; the next voxel follows with no gap.
//   a two-entry queue between the request side and the walker keeps
//   accepting requests while vertices drain.
// reset and stall
//   reset clears the queue, the walker, the output valid flag and the
//   origin registers. when rsp_tready is low the vertex register holds,
//   the walker halts, and req_tready drops once the queue is full.
module voxel_face_vertex_emitter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // block_x, block_y, block_z, block_kind, face_mask, tile_top,
   // tile_bottom, tile_west, tile_east, tile_north, tile_south, zero pad
   input  logic [vfve_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z, zero pad
   output logic [vfve_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [23:0]                          csr_data
);

   vfve_pkg::req_type   req;
   vfve_pkg::push_type  push;
   vfve_pkg::entry_type pop_entry;
   logic                queue_full;
   logic                pop_valid;
   logic                pop;

   assign req = vfve_pkg::req_type'(req_tdata[vfve_pkg::REQ_BITS-1:0]);

   vfve_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req        (req),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push)
   );

   vfve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop)
   );

   vfve_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/vfve_front.sv
// front end: origin registers, request accept, empty and range filtering
// depends on vfve_pkg
module vfve_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  vfve_pkg::req_type req,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_data,
   input  logic              queue_full,
   output vfve_pkg::push_type push
);

   logic [23:0] origin_x_ff, origin_x_in;
   logic [23:0] origin_y_ff, origin_y_in;
   logic [23:0] origin_z_ff, origin_z_in;
   logic        in_chunk;
   logic        visible;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      origin_z_in = origin_z_ff;
      if (csr_valid) begin
         case (csr_index)
            vfve_pkg::CSR_ORIGIN_X: origin_x_in = csr_data;
            vfve_pkg::CSR_ORIGIN_Y: origin_y_in = csr_data;
            vfve_pkg::CSR_ORIGIN_Z: origin_z_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         origin_z_ff <= origin_z_in;
      end
   end

   assign in_chunk = (32'(req.block_x) < vfve_pkg::CHUNK_EDGE)
                  && (32'(req.block_y) < vfve_pkg::CHUNK_EDGE)
                  && (32'(req.block_z) < vfve_pkg::CHUNK_EDGE);
   assign visible  = (req.block_kind != 8'd0) && (req.face_mask != 6'd0);

   always_comb begin
      push.valid           = req_tvalid && req_tready && visible && in_chunk;
      push.entry.tiles     = req.tiles;
      push.entry.face_mask = req.face_mask;
      push.entry.base_x    = {origin_x_ff[23], origin_x_ff} + {21'd0, req.block_x};
      push.entry.base_y    = {origin_y_ff[23], origin_y_ff} + {21'd0, req.block_y};
      push.entry.base_z    = {origin_z_ff[23], origin_z_ff} + {21'd0, req.block_z};
   end

endmodule

### rtl/vfve_queue.sv
// short queue of classified voxels between front and back end
// depends on vfve_pkg and the assertion macro header
`include "voxel_face_vertex_emitter_macros.svh"
module vfve_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  vfve_pkg::push_type   push,
   output logic                 full,
   output logic                 pop_valid,
   output vfve_pkg::entry_type  pop_entry,
   input  logic                 pop
);

   localparam int PtrW = vfve_pkg::QUEUE_PTR_W;
   localparam int CntW = vfve_pkg::QUEUE_CNT_W;

   vfve_pkg::entry_type slots_ff [vfve_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign full      = count_ff == CntW'(vfve_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `VFVE_ASSERT_NOW(a_count_bound, count_ff <= CntW'(vfve_pkg::QUEUE_DEPTH), "queue count overflow")
   `VFVE_ASSERT_IMPL(a_no_push_full, push.valid, !full, "push into full queue")

endmodule

### rtl/vfve_back.sv
// back end: walks visible faces and corners, drives the vertex output register
// depends on vfve_pkg and the assertion macro header
`include "voxel_face_vertex_emitter_macros.svh"
module vfve_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   input  vfve_pkg::entry_type                  pop_entry,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [vfve_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   localparam int TilesPerRow = vfve_pkg::ATLAS_TILES_PER_ROW;

   vfve_pkg::entry_type cur_ff, cur_in;
   logic                busy_ff, busy_in;
   logic [5:0]          rem_ff, rem_in;
   logic [2:0]          vtx_ff, vtx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   vfve_pkg::vert_type  vert_ff, vert_in;

   logic [2:0] face;
   logic       one_left;
   logic       step;
   logic       end_item;
   logic       load;
   logic [4:0] corner;
   logic [5:0] normal;
   logic [7:0] tile;
   logic [7:0] col;
   logic [7:0] row;
   logic [7:0] sum_u;
   logic [7:0] sum_v;

   always_comb begin
      face = 3'd0;
      for (int i = vfve_pkg::NUM_FACES - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            face = 3'(i);
         end
      end
   end

   assign one_left = (rem_ff & (rem_ff - 6'd1)) == 6'd0;
   assign step     = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign end_item = step && (vtx_ff == vfve_pkg::LAST_VERT) && one_left;
   assign load     = pop_valid && (!busy_ff || end_item);
   assign pop      = load;

   assign corner = vfve_pkg::CORNER_TAB[face][vtx_ff];
   assign normal = vfve_pkg::NORMAL_TAB[face];
   assign tile   = cur_ff.tiles[face];
   assign col    = 8'(tile % TilesPerRow);
   assign row    = 8'(tile / TilesPerRow);
   assign sum_u  = {7'd0, corner[1]} + col;
   assign sum_v  = {7'd0, corner[0]} + row;

   always_comb begin
      vert_in.pos_x    = cur_ff.base_x + {24'd0, corner[4]};
      vert_in.pos_y    = cur_ff.base_y + {24'd0, corner[3]};
      vert_in.pos_z    = cur_ff.base_z + {24'd0, corner[2]};
      vert_in.tex_u    = sum_u[4:0];
      vert_in.tex_v    = sum_v[4:0];
      vert_in.normal_x = normal[5:4];
      vert_in.normal_y = normal[3:2];
      vert_in.normal_z = normal[1:0];
   end

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      vtx_in       = vtx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (vtx_ff == vfve_pkg::LAST_VERT) && one_left;
         if (vtx_ff == vfve_pkg::LAST_VERT) begin
            vtx_in = 3'd0;
            rem_in = rem_ff & ~(6'd1 << face);
            if (one_left) begin
               busy_in = 1'b0;
            end
         end else begin
            vtx_in = vtx_ff + 3'd1;
         end
      end
      if (load) begin
         cur_in  = pop_entry;
         busy_in = 1'b1;
         rem_in  = pop_entry.face_mask;
         vtx_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_last_ff <= rsp_last_in;
      if (step) begin
         vert_ff <= vert_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(vfve_pkg::RSP_TDATA_W - vfve_pkg::VERT_BITS)'(0), vert_ff};

   `VFVE_ASSERT_IMPL(a_busy_has_face, busy_ff, rem_ff != 6'd0, "busy with no face left")
   `VFVE_ASSERT_IMPL(a_vtx_range, busy_ff, vtx_ff <= vfve_pkg::LAST_VERT, "corner index out of range")
   `VFVE_ASSERT_NEXT(a_load_starts, load, busy_ff && vtx_ff == 3'd0, "load did not start a voxel")

endmodule

### dv/tb_voxel_face_vertex_emitter.sv
// testbench for voxel_face_vertex_emitter: directed and random voxels with origin
// writes, a behavioral vertex predictor and an in-order vertex checker
// depends on vfve_pkg and the voxel_face_vertex_emitter rtl
`timescale 1ns / 1ps

module tb_voxel_face_vertex_emitter;

   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int DRAIN_CYCLES = 12;

   // corner bits {x, y, z, u, v} per face (+y, -y, -x, +x, -z, +z) and vertex
   localparam bit [4:0] FACE_CORNERS [6][6] = '{
      '{5'b01001, 5'b01100, 5'b11110, 5'b01001, 5'b11110, 5'b11011},
      '{5'b00000, 5'b10111, 5'b00101, 5'b00000, 5'b10010, 5'b10111},
      '{5'b00011, 5'b00101, 5'b01100, 5'b00011, 5'b01100, 5'b01010},
      '{5'b10001, 5'b11110, 5'b10111, 5'b10001, 5'b11000, 5'b11110},
      '{5'b00001, 5'b01000, 5'b11010, 5'b00001, 5'b11010, 5'b10011},
      '{5'b00111, 5'b11100, 5'b01110, 5'b00111, 5'b10101, 5'b11100}
   };
   localparam int FACE_NORMALS [6][3] = '{
      '{0, 1, 0}, '{0, -1, 0}, '{-1, 0, 0}, '{1, 0, 0}, '{0, 0, -1}, '{0, 0, 1}
   };

   typedef struct {
      vfve_pkg::vert_type vert;
      logic               last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [vfve_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [vfve_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [23:0] csr_data;

   logic signed [23:0] origin_x, origin_y, origin_z;
   vertex_type pending_vertices [$];
   int mismatch_count = 0;
   bit quiet = 1'b0;

   voxel_face_vertex_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 7);
   end

   function automatic void predict_vertices(vfve_pkg::req_type r);
      int wx, wy, wz, tile, count;
      bit [4:0] c;
      vertex_type v;
      count = 0;
      if (r.block_kind == 0 || r.face_mask == 0)
         return;
      wx = int'(origin_x) + int'(r.block_x);
      wy = int'(origin_y) + int'(r.block_y);
      wz = int'(origin_z) + int'(r.block_z);
      for (int f = 0; f < 6; f++) begin
         if (!r.face_mask[f])
            continue;
         tile = int'(r.tiles[f]);
         for (int k = 0; k < 6; k++) begin
            c = FACE_CORNERS[f][k];
            v.vert.pos_x = 25'(wx + c[4]);
            v.vert.pos_y = 25'(wy + c[3]);
            v.vert.pos_z = 25'(wz + c[2]);
            v.vert.tex_u = 5'((tile % vfve_pkg::ATLAS_TILES_PER_ROW) + c[1]);
            v.vert.tex_v = 5'((tile / vfve_pkg::ATLAS_TILES_PER_ROW) + c[0]);
            v.vert.normal_x = 2'(FACE_NORMALS[f][0]);
            v.vert.normal_y = 2'(FACE_NORMALS[f][1]);
            v.vert.normal_z = 2'(FACE_NORMALS[f][2]);
            v.last = 1'b0;
            pending_vertices.push_back(v);
            count++;
         end
      end
      if (count > 0)
         pending_vertices[pending_vertices.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      vertex_type want;
      vfve_pkg::vert_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = vfve_pkg::vert_type'(rsp_tdata[vfve_pkg::VERT_BITS-1:0]);
         if (pending_vertices.size() == 0) begin
            $error("vertex with nothing pending: pos %0d %0d %0d",
                   got.pos_x, got.pos_y, got.pos_z);
            mismatch_count++;
         end else begin
            want = pending_vertices.pop_front();
            compare_field("pos_x", want.vert.pos_x, got.pos_x);
            compare_field("pos_y", want.vert.pos_y, got.pos_y);
            compare_field("pos_z", want.vert.pos_z, got.pos_z);
            compare_field("tex_u", want.vert.tex_u, got.tex_u);
            compare_field("tex_v", want.vert.tex_v, got.tex_v);
            compare_field("normal_x", want.vert.normal_x, got.normal_x);
            compare_field("normal_y", want.vert.normal_y, got.normal_y);
            compare_field("normal_z", want.vert.normal_z, got.normal_z);
            compare_field("last_vertex", want.last, rsp_tlast);
         end
      end
   end

   task automatic send_voxel(vfve_pkg::req_type r);
      while (!quiet && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= vfve_pkg::REQ_TDATA_W'(r);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_vertices(r);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_origin(logic [1:0] index, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         vfve_pkg::CSR_ORIGIN_X: origin_x = value;
         vfve_pkg::CSR_ORIGIN_Y: origin_y = value;
         vfve_pkg::CSR_ORIGIN_Z: origin_z = value;
         default: ;
      endcase
   endtask

   task automatic set_origin(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      write_origin(vfve_pkg::CSR_ORIGIN_X, x);
      write_origin(vfve_pkg::CSR_ORIGIN_Y, y);
      write_origin(vfve_pkg::CSR_ORIGIN_Z, z);
   endtask

   function automatic vfve_pkg::req_type make_voxel(int bx, int by, int bz, int kind,
                                                    int mask, logic [47:0] tiles);
      vfve_pkg::req_type r;
      r.block_x = 4'(bx);
      r.block_y = 4'(by);
      r.block_z = 4'(bz);
      r.block_kind = 8'(kind);
      r.face_mask = 6'(mask);
      r.tiles = tiles;
      return r;
   endfunction

   function automatic vfve_pkg::req_type random_voxel();
      vfve_pkg::req_type r;
      r.block_x = 4'($urandom);
      r.block_y = 4'($urandom);
      r.block_z = 4'($urandom);
      r.block_kind = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      r.face_mask = ($urandom_range(19) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
      r.tiles = 48'({$urandom, $urandom});
      return r;
   endfunction

   task automatic test_reset_origin();
      send_voxel(make_voxel(0, 0, 0, 1, 6'h3f, 48'hff00_0f_f0_11_ee));
      drain();
   endtask

   task automatic test_empty_voxels();
      send_voxel(make_voxel(3, 4, 5, 0, 6'h3f, 48'h1234_5678_9abc));
      send_voxel(make_voxel(3, 4, 5, 200, 0, 48'h1234_5678_9abc));
      send_voxel(make_voxel(15, 15, 15, 0, 0, 48'hffff_ffff_ffff));
      send_voxel(make_voxel(7, 8, 9, 255, 6'h21, 48'h0102_0304_0506));
      drain();
   endtask

   task automatic test_each_face();
      logic [47:0] tiles;
      tiles = 48'h00_ff_0f_f0_5a_a5;
      for (int f = 0; f < 6; f++)
         send_voxel(make_voxel(f[0] ? 15 : 0, f[1] ? 15 : 0, (f > 3) ? 15 : 0,
                               f + 1, 1 << f, tiles));
      drain();
   endtask

   task automatic test_origin_extremes();
      set_origin(24'h7fffff, 24'h800000, 24'hffffff);
      send_voxel(make_voxel(15, 15, 15, 9, 6'h3f, 48'hffff_ffff_ffff));
      send_voxel(make_voxel(0, 0, 0, 9, 6'h3f, 48'h0000_0000_0000));
      drain();
      set_origin(24'h800000, 24'h7fffff, 24'h000001);
      send_voxel(make_voxel(15, 0, 15, 77, 6'h3f, 48'hf0f0_0f0f_8001));
      send_voxel(make_voxel(0, 15, 0, 77, 6'h2a, 48'h7f80_fe01_10ef));
      drain();
      set_origin(24'h000000, 24'h000000, 24'h000000);
      send_voxel(make_voxel(1, 2, 3, 4, 6'h15, 48'h4433_2211_0099));
      send_voxel(make_voxel(15, 15, 15, 128, 6'h3f, 48'hffee_ddcc_bbaa));
      drain();
      write_origin(CSR_UNMAPPED, 24'h5a5a5a);
      send_voxel(make_voxel(2, 2, 2, 3, 6'h3f, 48'h0011_2233_4455));
      drain();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_origin(24'($urandom), 24'($urandom), 24'($urandom));
            1: set_origin(24'h7fffff, 24'h7fffff, 24'h7fffff);
            2: set_origin(24'h800000, 24'h800000, 24'h800000);
            default: set_origin(24'($urandom), 24'($urandom), 24'($urandom));
         endcase
         if ($urandom_range(3) == 0)
            write_origin(CSR_UNMAPPED, 24'($urandom));
         quiet = (phase == 2);
         for (int n = 0; n < 68; n++)
            send_voxel(random_voxel());
         drain();
         quiet = 1'b0;
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= vfve_pkg::CSR_ORIGIN_X;
      csr_data <= '0;
      origin_x = '0;
      origin_y = '0;
      origin_z = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_origin();
      test_empty_voxels();
      test_each_face();
      test_origin_extremes();
      test_random();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### voxel_face_vertex_emitter.f
+incdir+rtl
rtl/vfve_pkg.sv
rtl/vfve_front.sv
rtl/vfve_queue.sv
rtl/vfve_back.sv
rtl/voxel_face_vertex_emitter.sv
dv/tb_voxel_face_vertex_emitter.sv
